// File: hw/rtl/ctok_pkg.sv
package ctok_pkg;

	typedef struct packed {
		logic [7:0] char_byte;
		logic       end_of_input;
	} in_word_t;

	typedef struct packed {
		logic [8:0]  token_kind;
		logic [2:0]  constant_kind;
		logic [15:0] line_no;
		logic [15:0] start_column;
		logic [8:0]  lexeme_length;
		logic        last_of_run;
	} out_word_t;

	// scanner modes, one-hot
	typedef enum logic [15:0] {
		M_IDLE    = 16'h0001,
		M_OP1     = 16'h0002,
		M_DOT2    = 16'h0004,
		M_SHIFT2  = 16'h0008,
		M_BLOCK   = 16'h0010,
		M_LINE    = 16'h0020,
		M_IDENT   = 16'h0040,
		M_ZERO    = 16'h0080,
		M_HEX     = 16'h0100,
		M_DEC     = 16'h0200,
		M_EXPSIGN = 16'h0400,
		M_SUFFIX  = 16'h0800,
		M_CHR     = 16'h1000,
		M_CHR_ESC = 16'h2000,
		M_STR     = 16'h4000,
		M_STR_ESC = 16'h8000
	} mode_t;

	localparam logic [8:0] K_EOF      = 9'd256;
	localparam logic [8:0] K_IDENT    = 9'd257;
	localparam logic [8:0] K_CONST    = 9'd258;
	localparam logic [8:0] K_STRING   = 9'd259;
	localparam logic [8:0] K_KW0      = 9'd260;
	localparam logic [8:0] K_ELLIPSIS = 9'd292;
	localparam logic [8:0] K_INC      = 9'd293;
	localparam logic [8:0] K_DEC      = 9'd294;
	localparam logic [8:0] K_PTR      = 9'd295;
	localparam logic [8:0] K_ADD_A    = 9'd296;
	localparam logic [8:0] K_SUB_A    = 9'd297;
	localparam logic [8:0] K_MUL_A    = 9'd298;
	localparam logic [8:0] K_DIV_A    = 9'd299;
	localparam logic [8:0] K_MOD_A    = 9'd300;
	localparam logic [8:0] K_AND_A    = 9'd301;
	localparam logic [8:0] K_OR_A     = 9'd302;
	localparam logic [8:0] K_XOR_A    = 9'd303;
	localparam logic [8:0] K_LEFT_A   = 9'd304;
	localparam logic [8:0] K_RIGHT_A  = 9'd305;
	localparam logic [8:0] K_LEFT     = 9'd306;
	localparam logic [8:0] K_RIGHT    = 9'd307;
	localparam logic [8:0] K_LE       = 9'd308;
	localparam logic [8:0] K_GE       = 9'd309;
	localparam logic [8:0] K_EQ       = 9'd310;
	localparam logic [8:0] K_NE       = 9'd311;
	localparam logic [8:0] K_ANDAND   = 9'd312;
	localparam logic [8:0] K_OROR     = 9'd313;
	localparam logic [8:0] K_NONE     = 9'd0;

	localparam logic [2:0] CK_NONE   = 3'd0;
	localparam logic [2:0] CK_INT    = 3'd1;
	localparam logic [2:0] CK_UNS    = 3'd2;
	localparam logic [2:0] CK_FLOAT  = 3'd3;
	localparam logic [2:0] CK_DOUBLE = 3'd4;
	localparam logic [2:0] CK_CHAR   = 3'd5;
	localparam logic [2:0] CK_STRING = 3'd6;

	// number flag bits
	localparam int NF_DOT = 0;
	localparam int NF_EXP = 1;
	localparam int NF_F   = 2;
	localparam int NF_U   = 3;

	// keywords, right-justified text and length
	localparam logic [63:0] KW_TEXT [32] = '{
		"auto", "break", "case", "char", "const", "continue", "default", "do",
		"double", "else", "enum", "extern", "float", "for", "goto", "if",
		"int", "long", "register", "return", "short", "signed", "sizeof", "static",
		"struct", "switch", "typedef", "union", "unsigned", "void", "volatile",
		"while"};
	localparam int KW_LEN [32] = '{
		4, 5, 4, 4, 5, 8, 7, 2,
		6, 4, 4, 6, 5, 3, 4, 2,
		3, 4, 8, 6, 5, 6, 6, 6,
		6, 6, 7, 5, 8, 4, 8, 5};

	function automatic logic is_alpha(input logic [7:0] c);
		return (c inside {[8'h61:8'h7a]}) || (c inside {[8'h41:8'h5a]});
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c inside {[8'h30:8'h39]};
	endfunction

	function automatic logic is_xdigit(input logic [7:0] c);
		return is_digit(c) || (c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]});
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'h20) || (c inside {[8'd9:8'd13]});
	endfunction

	function automatic logic op_first(input logic [7:0] c);
		return c inside {"+", "-", "*", "/", "%", "<", ">", "=", "!", "&", "|", "^", "."};
	endfunction

	// two-character operators; K_NONE when the pair is no operator
	function automatic logic [8:0] pair_op(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] k;
		k = K_NONE;
		if (b == "=") begin
			case (a)
				"+":     k = K_ADD_A;
				"-":     k = K_SUB_A;
				"*":     k = K_MUL_A;
				"/":     k = K_DIV_A;
				"%":     k = K_MOD_A;
				"&":     k = K_AND_A;
				"|":     k = K_OR_A;
				"^":     k = K_XOR_A;
				"<":     k = K_LE;
				">":     k = K_GE;
				"=":     k = K_EQ;
				"!":     k = K_NE;
				default: k = K_NONE;
			endcase
		end else if (a == b && a == "+") begin
			k = K_INC;
		end else if (a == b && a == "-") begin
			k = K_DEC;
		end else if (a == b && a == "&") begin
			k = K_ANDAND;
		end else if (a == b && a == "|") begin
			k = K_OROR;
		end else if (a == "-" && b == ">") begin
			k = K_PTR;
		end
		return k;
	endfunction

endpackage

// File: hw/rtl/ctok_kw.sv
module ctok_kw #(
	parameter int LW = 9
) (
	input  logic [7:0][7:0] kw_buf,
	input  logic [LW-1:0]   word_len,
	output logic [8:0]      kind
);
	import ctok_pkg::*;

	// parallel compare against all 32 keywords; only the first word_len bytes count
	always_comb begin
		logic hit;
		kind = K_IDENT;
		for (int i = 31; i >= 0; i--) begin
			hit = (word_len == LW'(KW_LEN[i]));
			for (int j = 0; j < 8; j++) begin
				if (j < KW_LEN[i]) begin
					hit = hit && (kw_buf[j] == KW_TEXT[i][8*(KW_LEN[i]-1-j) +: 8]);
				end
			end
			if (hit) begin
				kind = K_KW0 + 9'(i);
			end
		end
	end

endmodule

// File: hw/rtl/ctok_scan.sv
module ctok_scan #(
	parameter int MAX_WORD_LEN    = 255,
	parameter int MAX_LITERAL_LEN = 511,
	parameter int POSITION_BITS   = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  ctok_pkg::in_word_t            word,
	output ctok_pkg::out_word_t [2:0]     tok,
	output logic [1:0]                    tok_cnt
);
	import ctok_pkg::*;

	localparam int MAXL = (MAX_WORD_LEN > MAX_LITERAL_LEN) ? MAX_WORD_LEN : MAX_LITERAL_LEN;
	localparam int LW   = $clog2(MAXL + 1);
	localparam int PW   = POSITION_BITS;

	typedef struct packed {
		mode_t           mode;
		logic [PW-1:0]   tsl;
		logic [PW-1:0]   tsc;
		logic [LW-1:0]   len;
		logic [3:0]      nf;
		logic [7:0]      pop;
		logic [7:0]      pcc;
	} ctl_t;

	ctl_t            ctl_q, ctl_d;
	logic [7:0][7:0] kwb_q, kwb_d;
	logic [PW-1:0]   line_q, col_q, line_d, col_d;
	logic [8:0]      kw_kind;
	out_word_t [3:0] tk;
	logic [1:0]      n;

	ctok_kw #(.LW(LW)) u_kw (
		.kw_buf  (kwb_q),
		.word_len(ctl_q.len),
		.kind    (kw_kind)
	);

	function automatic logic [PW-1:0] sat_inc(input logic [PW-1:0] v);
		return (v == {PW{1'b1}}) ? v : v + 1'b1;
	endfunction

	function automatic out_word_t mk(input logic [8:0] kind, input logic [2:0] ck,
			input logic [PW-1:0] ln, input logic [PW-1:0] co, input logic [LW-1:0] len);
		out_word_t  o;
		logic [PW+15:0] eln, eco;
		logic [LW+8:0]  elen;
		eln  = {16'b0, ln};
		eco  = {16'b0, co};
		elen = {9'b0, len};
		o.token_kind    = kind;
		o.constant_kind = ck;
		o.line_no       = eln[15:0];
		o.start_column  = eco[15:0];
		o.lexeme_length = elen[8:0];
		o.last_of_run   = 1'b0;
		return o;
	endfunction

	function automatic logic [2:0] num_kind(input logic [3:0] nf);
		if (nf[NF_DOT] || nf[NF_EXP]) begin
			return nf[NF_F] ? CK_FLOAT : CK_DOUBLE;
		end
		return nf[NF_U] ? CK_UNS : CK_INT;
	endfunction

	always_comb begin
		ctl_t        s;
		logic [7:0]  c;
		logic        again;
		logic [8:0]  k;
		s      = ctl_q;
		kwb_d  = kwb_q;
		c      = word.char_byte;
		again  = 1'b0;
		k      = K_NONE;
		n      = 2'd0;
		tk     = '0;
		line_d = line_q;
		col_d  = col_q;
		if (word.end_of_input) begin
			case (s.mode)
				M_IDENT: begin
					tk[n] = mk(kw_kind, CK_NONE, s.tsl, s.tsc, s.len); n = n + 2'd1;
				end
				M_ZERO, M_HEX, M_DEC, M_EXPSIGN, M_SUFFIX: begin
					tk[n] = mk(K_CONST, num_kind(s.nf), s.tsl, s.tsc, s.len); n = n + 2'd1;
				end
				M_CHR, M_CHR_ESC: begin
					tk[n] = mk(K_CONST, CK_CHAR, s.tsl, s.tsc, s.len); n = n + 2'd1;
				end
				M_STR, M_STR_ESC: begin
					tk[n] = mk(K_STRING, CK_STRING, s.tsl, s.tsc, s.len); n = n + 2'd1;
				end
				M_OP1: begin
					tk[n] = mk({1'b0, s.pop}, CK_NONE, s.tsl, s.tsc, '0); n = n + 2'd1;
				end
				M_DOT2: begin
					tk[n] = mk(9'(8'h2e), CK_NONE, s.tsl, s.tsc, '0); n = n + 2'd1;
					tk[n] = mk(9'(8'h2e), CK_NONE, s.tsl, sat_inc(s.tsc), '0); n = n + 2'd1;
				end
				M_SHIFT2: begin
					tk[n] = mk((s.pop == "<") ? K_LEFT : K_RIGHT, CK_NONE, s.tsl, s.tsc, '0);
					n = n + 2'd1;
				end
				default: ;
			endcase
			tk[n] = mk(K_EOF, CK_NONE, line_q, col_q, '0); n = n + 2'd1;
			s.mode = M_IDLE;
			s.tsl  = PW'(1);
			s.tsc  = PW'(1);
			s.len  = '0;
			s.nf   = '0;
			s.pop  = '0;
			s.pcc  = '0;
			line_d = PW'(1);
			col_d  = PW'(1);
		end else begin
			again = 1'b1;
			// a byte that ends a token is rescanned; at most five passes
			for (int p = 0; p < 5; p++) begin
				if (again) begin
					again = 1'b0;
					case (s.mode)
						M_IDENT: begin
							if (c == "_" || is_alpha(c) || is_digit(c)) begin
								if (s.len < LW'(8)) kwb_d[s.len[2:0]] = c;
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else begin
								tk[n] = mk(kw_kind, CK_NONE, s.tsl, s.tsc, s.len); n = n + 2'd1;
								s.mode = M_IDLE;
								again  = 1'b1;
							end
						end
						M_ZERO: begin
							if (c == "x" || c == "X") begin
								s.len  = s.len + 1'b1;
								s.mode = M_HEX;
							end else begin
								s.mode = M_DEC;
								again  = 1'b1;
							end
						end
						M_HEX: begin
							if (is_xdigit(c)) begin
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else begin
								s.mode = M_SUFFIX;
								again  = 1'b1;
							end
						end
						M_DEC: begin
							if (is_digit(c)) begin
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else if (c == "." && !s.nf[NF_DOT]) begin
								s.nf[NF_DOT] = 1'b1;
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else if ((c == "e" || c == "E") && !s.nf[NF_EXP]) begin
								s.nf[NF_EXP] = 1'b1;
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
								s.mode = M_EXPSIGN;
							end else begin
								s.mode = M_SUFFIX;
								again  = 1'b1;
							end
						end
						M_EXPSIGN: begin
							s.mode = M_DEC;
							if (c == "+" || c == "-") begin
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else begin
								again = 1'b1;
							end
						end
						M_SUFFIX: begin
							if (is_alpha(c)) begin
								if (c == "f" || c == "F") s.nf[NF_F] = 1'b1;
								if (c == "u" || c == "U") s.nf[NF_U] = 1'b1;
								if (s.len < LW'(MAX_WORD_LEN)) s.len = s.len + 1'b1;
							end else begin
								tk[n] = mk(K_CONST, num_kind(s.nf), s.tsl, s.tsc, s.len);
								n = n + 2'd1;
								s.mode = M_IDLE;
								again  = 1'b1;
							end
						end
						M_CHR, M_STR: begin
							if (c == "\\") begin
								if (s.len < LW'(MAX_LITERAL_LEN)) s.len = s.len + 1'b1;
								s.mode = (s.mode == M_STR) ? M_STR_ESC : M_CHR_ESC;
							end else if ((s.mode == M_STR && c == "\"") ||
									(s.mode == M_CHR && (c == "'" || c == 8'h0a))) begin
								if (s.mode == M_STR) begin
									tk[n] = mk(K_STRING, CK_STRING, s.tsl, s.tsc, s.len);
								end else begin
									tk[n] = mk(K_CONST, CK_CHAR, s.tsl, s.tsc, s.len);
								end
								n = n + 2'd1;
								s.mode = M_IDLE;
							end else begin
								if (s.len < LW'(MAX_LITERAL_LEN)) s.len = s.len + 1'b1;
							end
						end
						M_CHR_ESC, M_STR_ESC: begin
							if (s.len < LW'(MAX_LITERAL_LEN)) s.len = s.len + 1'b1;
							s.mode = (s.mode == M_STR_ESC) ? M_STR : M_CHR;
						end
						M_OP1: begin
							if (s.pop == "/" && c == "*") begin
								s.mode = M_BLOCK;
								s.pcc  = '0;
							end else if (s.pop == "/" && c == "/") begin
								s.mode = M_LINE;
							end else if (s.pop == "." && c == ".") begin
								s.mode = M_DOT2;
							end else if ((s.pop == "<" || s.pop == ">") && c == s.pop) begin
								s.mode = M_SHIFT2;
							end else begin
								k = pair_op(s.pop, c);
								s.mode = M_IDLE;
								if (k != K_NONE) begin
									tk[n] = mk(k, CK_NONE, s.tsl, s.tsc, '0);
								end else begin
									tk[n] = mk({1'b0, s.pop}, CK_NONE, s.tsl, s.tsc, '0);
									again = 1'b1;
								end
								n = n + 2'd1;
							end
						end
						M_DOT2: begin
							s.mode = M_IDLE;
							if (c == ".") begin
								tk[n] = mk(K_ELLIPSIS, CK_NONE, s.tsl, s.tsc, '0); n = n + 2'd1;
							end else begin
								tk[n] = mk(9'(8'h2e), CK_NONE, s.tsl, s.tsc, '0); n = n + 2'd1;
								tk[n] = mk(9'(8'h2e), CK_NONE, s.tsl, sat_inc(s.tsc), '0);
								n = n + 2'd1;
								again = 1'b1;
							end
						end
						M_SHIFT2: begin
							s.mode = M_IDLE;
							if (c == "=") begin
								tk[n] = mk((s.pop == "<") ? K_LEFT_A : K_RIGHT_A, CK_NONE,
									s.tsl, s.tsc, '0);
							end else begin
								tk[n] = mk((s.pop == "<") ? K_LEFT : K_RIGHT, CK_NONE,
									s.tsl, s.tsc, '0);
								again = 1'b1;
							end
							n = n + 2'd1;
						end
						M_BLOCK: begin
							if (s.pcc == "*" && c == "/") s.mode = M_IDLE;
							else s.pcc = c;
						end
						M_LINE: begin
							if (c == 8'h0a) s.mode = M_IDLE;
						end
						default: begin
							s.mode = M_IDLE;
							if (!is_space(c)) begin
								s.tsl = line_q;
								s.tsc = col_q;
								if (c == "_" || is_alpha(c)) begin
									s.mode   = M_IDENT;
									kwb_d[0] = c;
									s.len    = LW'(1);
								end else if (is_digit(c)) begin
									s.mode = (c == "0") ? M_ZERO : M_DEC;
									s.len  = LW'(1);
									s.nf   = '0;
								end else if (c == "'" || c == "\"") begin
									s.mode = (c == "\"") ? M_STR : M_CHR;
									s.len  = '0;
								end else if (op_first(c)) begin
									s.mode = M_OP1;
									s.pop  = c;
								end else begin
									tk[n] = mk({1'b0, c}, CK_NONE, line_q, col_q, '0);
									n = n + 2'd1;
								end
							end
						end
					endcase
				end
			end
			if (c == 8'h0a) begin
				line_d = sat_inc(line_q);
				col_d  = PW'(1);
			end else begin
				col_d = sat_inc(col_q);
			end
		end
		if (n != 2'd0) tk[n - 2'd1].last_of_run = 1'b1;
		ctl_d   = s;
		tok     = tk[2:0];
		tok_cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q.mode <= M_IDLE;
			ctl_q.tsl  <= PW'(1);
			ctl_q.tsc  <= PW'(1);
			ctl_q.len  <= '0;
			ctl_q.nf   <= '0;
			ctl_q.pop  <= '0;
			ctl_q.pcc  <= '0;
			line_q     <= PW'(1);
			col_q      <= PW'(1);
		end else if (take) begin
			ctl_q  <= ctl_d;
			line_q <= line_d;
			col_q  <= col_d;
		end
	end

	// keyword buffer: the first bytes of the current word; bytes past its length may be left from an earlier word
	always_ff @(posedge clk) begin
		if (take) kwb_q <= kwb_d;
	end

endmodule

// File: hw/rtl/ctok_fifo.sv
module ctok_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ctok_pkg::out_word_t [2:0] push_data,
	input  logic [1:0]                push_cnt,
	output logic                      room,
	output logic                      valid,
	input  logic                      ready,
	output ctok_pkg::out_word_t       data
);
	import ctok_pkg::*;

	out_word_t  mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign valid = (cnt_q != 3'd0);
	assign pop   = valid && ready;
	assign data  = mem_q[rd_q];
	// three free slots cover the largest burst of one byte
	assign room  = (cnt_q <= 3'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + push_cnt;
			rd_q  <= rd_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_cnt} - {2'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < push_cnt) mem_q[wr_q + 2'(i)] <= push_data[i];
		end
	end

endmodule

// File: hw/rtl/c_source_tokenizer_top.sv
// channel | signals                      | word
// in      | in_valid, in_ready, in_data  | one source byte or end mark
// out     | out_valid, out_ready, out_data | one token
//
// Each byte is scanned in the cycle it is taken; a new byte can be taken every
// cycle. One byte yields zero to three tokens, queued in a four-entry token
// queue and handed out one per cycle while out_ready is high, so the queue drain
// rate bounds throughput. in_ready drops while fewer than three queue slots are
// free. Reset (arst_n low) puts the scanner between tokens at line 1, column 1.
module c_source_tokenizer_top #(
	parameter int MAX_WORD_LEN    = 255,
	parameter int MAX_LITERAL_LEN = 511,
	parameter int POSITION_BITS   = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  ctok_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output ctok_pkg::out_word_t out_data
);
	import ctok_pkg::*;

	out_word_t [2:0] tok;
	logic [1:0]      tok_cnt;
	logic            take;

	assign take = in_valid && in_ready;

	// scanner: mode, positions, lengths and keyword buffer
	ctok_scan #(
		.MAX_WORD_LEN   (MAX_WORD_LEN),
		.MAX_LITERAL_LEN(MAX_LITERAL_LEN),
		.POSITION_BITS  (POSITION_BITS)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.word   (in_data),
		.tok    (tok),
		.tok_cnt(tok_cnt)
	);

	// token queue; pushes only on a taken byte
	ctok_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push_data(tok),
		.push_cnt (take ? tok_cnt : 2'd0),
		.room     (in_ready),
		.valid    (out_valid),
		.ready    (out_ready),
		.data     (out_data)
	);

endmodule

// File: verif/tb_c_source_tokenizer_top.sv
`timescale 1ns / 100ps

module tb_c_source_tokenizer_top;
	import ctok_pkg::*;

	// local scan states of the predictor
	typedef enum int {
		S_IDLE, S_OP1, S_DOT2, S_SHIFT2, S_BLOCK, S_LINE, S_IDENT, S_ZERO,
		S_HEX, S_DEC, S_EXPSIGN, S_SUFFIX, S_CHR, S_CHR_ESC, S_STR, S_STR_ESC
	} scan_t;

	localparam int MAX_WORD = 255;
	localparam int MAX_LIT  = 511;
	localparam int POS_MAX  = 65535;
	localparam int CYCLE_LIMIT = 400000;

	// token predictor and in-order checker
	class token_scoreboard;
		out_word_t pending_tokens[$];
		int errors;
		scan_t mode;
		int unsigned cur_line, cur_col, tok_line, tok_col, len;
		logic [7:0] word_head[8];
		logic [3:0] num_flags;
		logic [7:0] op_char, prev_cmt;
		out_word_t run[$];

		function void clear_state();
			mode = S_IDLE;
			cur_line = 1;
			cur_col = 1;
			tok_line = 1;
			tok_col = 1;
			len = 0;
			num_flags = '0;
			op_char = '0;
			prev_cmt = '0;
		endfunction

		function new();
			errors = 0;
			clear_state();
		endfunction

		function void push_token(logic [8:0] kind, logic [2:0] ck, int unsigned ln,
				int unsigned co, int unsigned lx);
			out_word_t w;
			w.token_kind = kind;
			w.constant_kind = ck;
			w.line_no = ln[15:0];
			w.start_column = co[15:0];
			w.lexeme_length = lx[8:0];
			w.last_of_run = 1'b0;
			if (run.size() < 3)
				run.push_back(w);
		endfunction

		function void close_word();
			logic [8:0] kind;
			bit same;
			kind = K_IDENT;
			if (len <= 8) begin
				for (int i = 0; i < 32; i++) begin
					same = (KW_LEN[i] == len);
					for (int j = 0; j < len && same; j++)
						if (KW_TEXT[i][8 * (len - 1 - j) +: 8] != word_head[j])
							same = 0;
					if (same && kind == K_IDENT)
						kind = K_KW0 + i[8:0];
				end
			end
			push_token(kind, CK_NONE, tok_line, tok_col, len);
		endfunction

		function void close_number();
			logic [2:0] ck;
			if (num_flags[NF_DOT] || num_flags[NF_EXP])
				ck = num_flags[NF_F] ? CK_FLOAT : CK_DOUBLE;
			else
				ck = num_flags[NF_U] ? CK_UNS : CK_INT;
			push_token(K_CONST, ck, tok_line, tok_col, len);
		endfunction

		function void two_dots();
			push_token(9'h02e, CK_NONE, tok_line, tok_col, 0);
			push_token(9'h02e, CK_NONE, tok_line,
				(tok_col >= POS_MAX) ? POS_MAX : tok_col + 1, 0);
		endfunction

		function void word_grow();
			if (len < MAX_WORD)
				len++;
		endfunction

		function void lit_grow();
			if (len < MAX_LIT)
				len++;
		endfunction

		function void begin_token(logic [7:0] c);
			if (is_space(c))
				return;
			tok_line = cur_line;
			tok_col = cur_col;
			if (c == "_" || is_alpha(c)) begin
				mode = S_IDENT;
				word_head[0] = c;
				len = 1;
			end else if (is_digit(c)) begin
				mode = (c == "0") ? S_ZERO : S_DEC;
				len = 1;
				num_flags = '0;
			end else if (c == "'" || c == "\"") begin
				mode = (c == "\"") ? S_STR : S_CHR;
				len = 0;
			end else if (op_first(c)) begin
				mode = S_OP1;
				op_char = c;
			end else begin
				push_token({1'b0, c}, CK_NONE, cur_line, cur_col, 0);
			end
		endfunction

		function void scan(logic [7:0] c);
			bit again;
			bit str;
			logic [8:0] k;
			again = 1;
			while (again) begin
				again = 0;
				case (mode)
					S_IDENT: begin
						if (c == "_" || is_alpha(c) || is_digit(c)) begin
							if (len < 8)
								word_head[len] = c;
							word_grow();
						end else begin
							close_word();
							mode = S_IDLE;
							again = 1;
						end
					end
					S_ZERO: begin
						if (c == "x" || c == "X") begin
							len++;
							mode = S_HEX;
						end else begin
							mode = S_DEC;
							again = 1;
						end
					end
					S_HEX: begin
						if (is_xdigit(c))
							word_grow();
						else begin
							mode = S_SUFFIX;
							again = 1;
						end
					end
					S_DEC: begin
						if (is_digit(c))
							word_grow();
						else if (c == "." && !num_flags[NF_DOT]) begin
							num_flags[NF_DOT] = 1;
							word_grow();
						end else if ((c == "e" || c == "E") && !num_flags[NF_EXP]) begin
							num_flags[NF_EXP] = 1;
							word_grow();
							mode = S_EXPSIGN;
						end else begin
							mode = S_SUFFIX;
							again = 1;
						end
					end
					S_EXPSIGN: begin
						mode = S_DEC;
						if (c == "+" || c == "-")
							word_grow();
						else
							again = 1;
					end
					S_SUFFIX: begin
						if (is_alpha(c)) begin
							if (c == "f" || c == "F")
								num_flags[NF_F] = 1;
							if (c == "u" || c == "U")
								num_flags[NF_U] = 1;
							word_grow();
						end else begin
							close_number();
							mode = S_IDLE;
							again = 1;
						end
					end
					S_CHR, S_STR: begin
						str = (mode == S_STR);
						if (c == "\\") begin
							lit_grow();
							mode = str ? S_STR_ESC : S_CHR_ESC;
						end else if (c == (str ? 8'h22 : 8'h27) || (!str && c == 8'h0a)) begin
							push_token(str ? K_STRING : K_CONST, str ? CK_STRING : CK_CHAR,
								tok_line, tok_col, len);
							mode = S_IDLE;
						end else
							lit_grow();
					end
					S_CHR_ESC: begin
						lit_grow();
						mode = S_CHR;
					end
					S_STR_ESC: begin
						lit_grow();
						mode = S_STR;
					end
					S_OP1: begin
						if (op_char == "/" && c == "*") begin
							mode = S_BLOCK;
							prev_cmt = '0;
						end else if (op_char == "/" && c == "/")
							mode = S_LINE;
						else if (op_char == "." && c == ".")
							mode = S_DOT2;
						else if ((op_char == "<" || op_char == ">") && c == op_char)
							mode = S_SHIFT2;
						else begin
							k = pair_op(op_char, c);
							mode = S_IDLE;
							if (k != K_NONE)
								push_token(k, CK_NONE, tok_line, tok_col, 0);
							else begin
								push_token({1'b0, op_char}, CK_NONE, tok_line, tok_col, 0);
								again = 1;
							end
						end
					end
					S_DOT2: begin
						mode = S_IDLE;
						if (c == ".")
							push_token(K_ELLIPSIS, CK_NONE, tok_line, tok_col, 0);
						else begin
							two_dots();
							again = 1;
						end
					end
					S_SHIFT2: begin
						mode = S_IDLE;
						if (c == "=")
							push_token((op_char == "<") ? K_LEFT_A : K_RIGHT_A, CK_NONE,
								tok_line, tok_col, 0);
						else begin
							push_token((op_char == "<") ? K_LEFT : K_RIGHT, CK_NONE,
								tok_line, tok_col, 0);
							again = 1;
						end
					end
					S_BLOCK: begin
						if (prev_cmt == "*" && c == "/")
							mode = S_IDLE;
						else
							prev_cmt = c;
					end
					S_LINE: begin
						if (c == 8'h0a)
							mode = S_IDLE;
					end
					default: begin
						mode = S_IDLE;
						begin_token(c);
					end
				endcase
			end
		endfunction

		function void flush();
			case (mode)
				S_IDENT: close_word();
				S_ZERO, S_HEX, S_DEC, S_EXPSIGN, S_SUFFIX: close_number();
				S_CHR, S_CHR_ESC: push_token(K_CONST, CK_CHAR, tok_line, tok_col, len);
				S_STR, S_STR_ESC: push_token(K_STRING, CK_STRING, tok_line, tok_col, len);
				S_OP1: push_token({1'b0, op_char}, CK_NONE, tok_line, tok_col, 0);
				S_DOT2: two_dots();
				S_SHIFT2: push_token((op_char == "<") ? K_LEFT : K_RIGHT, CK_NONE,
					tok_line, tok_col, 0);
				default: ;
			endcase
		endfunction

		// predict the tokens of one accepted word
		function void note_input(in_word_t w);
			run.delete();
			if (w.end_of_input) begin
				flush();
				push_token(K_EOF, CK_NONE, cur_line, cur_col, 0);
				clear_state();
			end else begin
				scan(w.char_byte);
				if (w.char_byte == 8'h0a) begin
					cur_line = (cur_line >= POS_MAX) ? POS_MAX : cur_line + 1;
					cur_col = 1;
				end else
					cur_col = (cur_col >= POS_MAX) ? POS_MAX : cur_col + 1;
			end
			if (run.size() > 0)
				run[run.size() - 1].last_of_run = 1'b1;
			foreach (run[i])
				pending_tokens.push_back(run[i]);
		endfunction

		function void check_token(out_word_t got);
			out_word_t exp_w;
			if (pending_tokens.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected token %p", got);
				return;
			end
			exp_w = pending_tokens.pop_front();
			if (got !== exp_w) begin
				errors++;
				if (errors <= 10)
					$display("token mismatch: expected %p, got %p", exp_w, got);
			end
		endfunction
	endclass

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      in_valid = 1'b0;
	logic      in_ready;
	in_word_t  in_data = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_word_t out_data;

	token_scoreboard sb = new();
	int  cycle_count = 0;
	int  idle_pct = 14;     // percent of cycles each side idles
	bit  hold_off = 0;      // long receiver stall, counted in its own process
	bit  stim_done = 0;

	c_source_tokenizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// scoreboard hooks sample at the edge, before the NBA updates land
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_input(in_data);
		if (arst_n && out_valid && out_ready)
			sb.check_token(out_data);
	end

	// receiver: random stalls, or a long hold-off when requested
	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= !hold_off && ($urandom_range(99) >= idle_pct);
	end

	// drive one word; valid stays high until it is taken and is dropped only
	// by an idle cycle or by the caller once the stream pauses
	task automatic send_word(logic [7:0] c, logic eoi);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{char_byte: c, end_of_input: eoi};
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_word(s[i], 1'b0);
	endtask

	task automatic end_source();
		send_word(8'($urandom_range(255)), 1'b1);
	endtask

	// random but mostly well-formed C fragments
	task automatic send_fragment();
		string frags[$];
		string lone;
		int sel;
		frags = '{"int ", "while", " x_1", "0x1Fu ", "3.5e-2f ", "12UL;", "'\\n'",
			"\"a\\\"b\" ", "/* c* */", "// ln\n", "->", "<<=", ">>", "...", "..;",
			"&&", "||", "!=", "+=", "++", "--", "a.b", "unsigned ", "volatile ",
			"\t\n", "{ }", "1e+5", ".5", "0.", "'x"};
		sel = $urandom_range(9);
		if (sel < 7)
			send_text(frags[$urandom_range(frags.size() - 1)]);
		else if (sel < 9)
			send_word(8'($urandom_range(255)), 1'b0);   // noise byte
		else begin
			lone = "abcdefghijklmnopqrstuvwxyz_";
			send_word(lone[$urandom_range(26)], 1'b0);
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: keywords, operators, numbers, literals, comments, dot repair
		send_text("auto break case char const continue default do double else ");
		end_source();
		send_text("a+=b;..x...<<>>=//c\n/*x*/'\\''\"s\\n\"0x0.5e+1fU 0e\xff\x00");
		end_source();
		send_text("..");
		end_source();
		send_text("\"open");
		end_source();
		send_text("/* open");
		end_source();
		send_text("abcdefghijk");
		end_source();
		send_text("'a\n<");
		end_source();

		// random with no idling, then with a long receiver hold-off
		idle_pct = 0;
		repeat (20)
			send_fragment();
		idle_pct = 14;
		hold_off = 1;
		fork
			begin
				repeat (10)
					send_fragment();
				in_valid <= 1'b0;
			end
			begin
				repeat (200) @(posedge clk);
				hold_off = 0;
			end
		join
		while (hold_off)
			@(posedge clk);
		repeat (55) begin
			send_fragment();
			if ($urandom_range(15) == 0)
				end_source();
		end
		end_source();
		in_valid <= 1'b0;
		stim_done = 1;
	end

	// end of run: drain, settle, judge; or time out
	initial begin
		wait (stim_done);
		while (sb.pending_tokens.size() != 0 && cycle_count < CYCLE_LIMIT)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (cycle_count < CYCLE_LIMIT) begin
			if (sb.errors == 0 && sb.pending_tokens.size() == 0)
				$display("DONE: 0 errors");
			else
				$display("DONE: errors detected");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
